// File: design/mcr_pkg.sv
// mcr_pkg: shared widths, constants and types of the midpoint circle rasterizer
// used by the channel interfaces, the front queue, the back engine and the top level
package mcr_pkg;

   // field widths
   localparam int COORD_BITS  = 11;
   localparam int RADIUS_BITS = 10;
   localparam int PIX_BITS    = 13;
   localparam int OFF_BITS    = RADIUS_BITS + 2;
   localparam int DEC_BITS    = 16;

   // eight-way symmetry, one pixel per cycle while the result channel is ready
   localparam int PIX_PER_POINT = 8;
   localparam int IDX_BITS      = $clog2(PIX_PER_POINT);
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(PIX_PER_POINT - 1);

   // command queue between front and back
   localparam int QDEPTH    = 2;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);

   // decision variable constants of the midpoint scheme
   localparam logic signed [DEC_BITS-1:0] DEC_INIT   = DEC_BITS'(3);
   localparam logic signed [DEC_BITS-1:0] DEC_DIAG   = DEC_BITS'(10);
   localparam logic signed [DEC_BITS-1:0] DEC_AXIAL  = DEC_BITS'(6);

   // item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_EMIT,
      MODE_DONE
   } mode_type;

   typedef struct packed {
      logic                   is_step;
      logic [COORD_BITS-1:0]  center_x;
      logic [COORD_BITS-1:0]  center_y;
      logic [RADIUS_BITS-1:0] radius;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic     pop;
      mode_type mode;
   } back_ctl_type;

endpackage

// File: design/mcr_if.sv
// mcr_if: valid/ready channel interfaces for circle commands and pixel results
// depends on mcr_pkg for the field widths
interface mcr_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [mcr_pkg::COORD_BITS-1:0] center_x;
   logic [mcr_pkg::COORD_BITS-1:0] center_y;
   logic [mcr_pkg::RADIUS_BITS-1:0] radius;

   modport source (output valid, kind, center_x, center_y, radius, input ready);
   modport sink (input valid, kind, center_x, center_y, radius, output ready);
endinterface

interface mcr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x;
   logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y;
   logic                                pixel_valid;
   logic                                last;
   logic                                done_res;

   modport source (output valid, pixel_x, pixel_y, pixel_valid, last, done_res,
                   input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_valid, last, done_res,
                 output ready);
endinterface

// File: design/mcr_front.sv
// mcr_front: accepts command items, tags them start or step and queues them
// depends on mcr_pkg and mcr_req_if
module mcr_front (
   input  logic                    clock,
   input  logic                    reset,
   mcr_req_if.sink                 req_chan,
   input  logic                    pop,
   output mcr_pkg::queue_head_type queue_head
);

   mcr_pkg::cmd_type                 queue_mem [mcr_pkg::QDEPTH];
   logic [mcr_pkg::QPTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mcr_pkg::QPTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [mcr_pkg::QCNT_BITS-1:0]    count_ff, count_in;
   logic                             push;
   logic                             pop_ok;
   mcr_pkg::cmd_type                 new_cmd;

   // accept while there is room
   assign req_chan.ready = (count_ff != mcr_pkg::QCNT_BITS'(mcr_pkg::QDEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign pop_ok         = pop && (count_ff != '0);

   // classify the item
   always_comb begin
      new_cmd.is_step  = (req_chan.kind == mcr_pkg::KIND_STEP);
      new_cmd.center_x = req_chan.center_x;
      new_cmd.center_y = req_chan.center_y;
      new_cmd.radius   = req_chan.radius;
   end

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mcr_pkg::QPTR_BITS'(mcr_pkg::QDEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == mcr_pkg::QPTR_BITS'(mcr_pkg::QDEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= new_cmd;
      end
   end

   // head of queue to the back end
   assign queue_head.valid = (count_ff != '0);
   assign queue_head.cmd   = queue_mem[rd_ptr_ff];

endmodule

// File: design/mcr_back.sv
// mcr_back: midpoint circle engine; per command updates offsets and decision, streams
// eight mirrored pixels or a done result via an output register; depends on mcr_pkg, mcr_rsp_if
module mcr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mcr_pkg::queue_head_type queue_head,
   output mcr_pkg::back_ctl_type   back_ctl,
   mcr_rsp_if.source               rsp_chan
);

   mcr_pkg::mode_type                        mode_ff, mode_in;
   logic [mcr_pkg::IDX_BITS-1:0]             idx_ff, idx_in;
   logic                                     active_ff, active_in;
   logic signed [mcr_pkg::OFF_BITS-1:0]      off_a_ff, off_a_in;
   logic signed [mcr_pkg::OFF_BITS-1:0]      off_b_ff, off_b_in;
   logic signed [mcr_pkg::DEC_BITS-1:0]      decision_ff, decision_in;
   logic [mcr_pkg::COORD_BITS-1:0]           centre_x_ff, centre_x_in;
   logic [mcr_pkg::COORD_BITS-1:0]           centre_y_ff, centre_y_in;

   logic                                     out_valid_ff, out_valid_in;
   logic signed [mcr_pkg::PIX_BITS-1:0]      out_x_ff, out_x_in;
   logic signed [mcr_pkg::PIX_BITS-1:0]      out_y_ff, out_y_in;
   logic                                     out_pix_ff, out_pix_in;
   logic                                     out_last_ff, out_last_in;
   logic                                     out_done_ff, out_done_in;

   logic                                     advance;
   logic                                     finishing;
   logic                                     can_take;
   logic                                     pop;
   logic                                     step_live;
   logic signed [mcr_pkg::OFF_BITS-1:0]      a_next;
   logic signed [mcr_pkg::OFF_BITS-1:0]      b_dec;
   logic signed [mcr_pkg::OFF_BITS-1:0]      diag_diff;
   logic signed [mcr_pkg::DEC_BITS-1:0]      diag_term;
   logic signed [mcr_pkg::DEC_BITS-1:0]      axial_term;
   logic signed [mcr_pkg::DEC_BITS-1:0]      radius_x2;
   logic signed [mcr_pkg::PIX_BITS-1:0]      cx_pix, cy_pix;
   logic signed [mcr_pkg::PIX_BITS-1:0]      off_u, off_v;
   logic signed [mcr_pkg::PIX_BITS-1:0]      pix_x, pix_y;

   // output register moves when empty or taken
   assign advance   = !out_valid_ff || rsp_chan.ready;
   assign finishing = advance && ((mode_ff == mcr_pkg::MODE_DONE) ||
                      ((mode_ff == mcr_pkg::MODE_EMIT) && (idx_ff == mcr_pkg::LAST_IDX)));
   assign can_take  = (mode_ff == mcr_pkg::MODE_IDLE) || finishing;
   assign pop       = queue_head.valid && can_take;

   // a step draws only while the octant is open
   assign step_live = active_ff && !(off_b_ff < off_a_ff);

   // midpoint decision update terms
   assign a_next     = off_a_ff + mcr_pkg::OFF_BITS'(1);
   assign b_dec      = off_b_ff - mcr_pkg::OFF_BITS'(1);
   assign diag_diff  = a_next - b_dec;
   assign diag_term  = (mcr_pkg::DEC_BITS'(diag_diff) <<< 2) + mcr_pkg::DEC_DIAG;
   assign axial_term = (mcr_pkg::DEC_BITS'(a_next) <<< 2) + mcr_pkg::DEC_AXIAL;
   assign radius_x2  = mcr_pkg::DEC_BITS'({1'b0, queue_head.cmd.radius, 1'b0});

   // mirrored pixel for the current slot
   always_comb begin
      cx_pix = mcr_pkg::PIX_BITS'({1'b0, centre_x_ff});
      cy_pix = mcr_pkg::PIX_BITS'({1'b0, centre_y_ff});
      off_u  = idx_ff[2] ? mcr_pkg::PIX_BITS'(off_b_ff) : mcr_pkg::PIX_BITS'(off_a_ff);
      off_v  = idx_ff[2] ? mcr_pkg::PIX_BITS'(off_a_ff) : mcr_pkg::PIX_BITS'(off_b_ff);
      pix_x  = idx_ff[0] ? cx_pix - off_u : cx_pix + off_u;
      pix_y  = idx_ff[1] ? cy_pix - off_v : cy_pix + off_v;
   end

   // sequencer: next state, circle state and output register
   always_comb begin
      mode_in      = mode_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      off_a_in     = off_a_ff;
      off_b_in     = off_b_ff;
      decision_in  = decision_ff;
      centre_x_in  = centre_x_ff;
      centre_y_in  = centre_y_ff;
      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;

      // drain the output register
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      // load one result
      case (mode_ff)
         mcr_pkg::MODE_EMIT: begin
            if (advance) begin
               out_valid_in = 1'b1;
               out_x_in     = pix_x;
               out_y_in     = pix_y;
               out_pix_in   = 1'b1;
               out_last_in  = (idx_ff == mcr_pkg::LAST_IDX);
               out_done_in  = 1'b0;
               idx_in       = idx_ff + 1'b1;
            end
         end
         mcr_pkg::MODE_DONE: begin
            if (advance) begin
               out_valid_in = 1'b1;
               out_x_in     = '0;
               out_y_in     = '0;
               out_pix_in   = 1'b0;
               out_last_in  = 1'b1;
               out_done_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (finishing) begin
         mode_in = mcr_pkg::MODE_IDLE;
      end

      // take the next command
      if (pop) begin
         idx_in = '0;
         if (!queue_head.cmd.is_step) begin
            centre_x_in = queue_head.cmd.center_x;
            centre_y_in = queue_head.cmd.center_y;
            off_a_in    = '0;
            off_b_in    = mcr_pkg::OFF_BITS'({1'b0, queue_head.cmd.radius});
            decision_in = mcr_pkg::DEC_INIT - radius_x2;
            active_in   = 1'b1;
            mode_in     = mcr_pkg::MODE_EMIT;
         end else if (step_live) begin
            off_a_in = a_next;
            if (!decision_ff[mcr_pkg::DEC_BITS-1] && (decision_ff != '0)) begin
               off_b_in    = b_dec;
               decision_in = decision_ff + diag_term;
            end else begin
               decision_in = decision_ff + axial_term;
            end
            mode_in = mcr_pkg::MODE_EMIT;
         end else begin
            active_in = 1'b0;
            mode_in   = mcr_pkg::MODE_DONE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= mcr_pkg::MODE_IDLE;
         idx_ff       <= '0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         idx_ff       <= idx_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // circle state and result payload
   always_ff @(posedge clock) begin
      off_a_ff    <= off_a_in;
      off_b_ff    <= off_b_in;
      decision_ff <= decision_in;
      centre_x_ff <= centre_x_in;
      centre_y_ff <= centre_y_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_pix_ff  <= out_pix_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_x     = out_x_ff;
   assign rsp_chan.pixel_y     = out_y_ff;
   assign rsp_chan.pixel_valid = out_pix_ff;
   assign rsp_chan.last        = out_last_ff;
   assign rsp_chan.done_res    = out_done_ff;

   assign back_ctl.pop  = pop;
   assign back_ctl.mode = mode_ff;

endmodule

// File: design/midpoint_circle_rasterizer_core.sv
// midpoint_circle_rasterizer_core: top level of the midpoint circle rasterizer
// depends on mcr_pkg, mcr_req_if, mcr_rsp_if, mcr_front and mcr_back
//
// Usage
//   req_chan carries commands: kind start (with center_x, center_y, radius)
//   or kind step. rsp_chan carries results: a start, or a step while the
//   octant is open, gives eight mirrored pixels with last on the eighth; a
//   step after the octant is closed (or with no circle) gives one result with
//   done_res and last set and pixel_valid clear.
//   Commands enter a two-entry queue; the engine pops one while it sends the
//   final result of the previous one, so commands run back to back.
//   A command taken with the engine idle passes the queue, the engine
//   state registers and the output register before its first result.
//   Throughput: one pixel per cycle while rsp_chan.ready is high, set by
//   the single output register port.
//   Reset (synchronous) empties the queue and the output register and
//   clears the circle in progress.
//   When rsp_chan.ready is low the output register holds its result, the
//   engine waits, and req_chan keeps taking commands until the queue fills.
module midpoint_circle_rasterizer_core (
   input  logic      clock,
   input  logic      reset,
   mcr_req_if.sink   req_chan,
   mcr_rsp_if.source rsp_chan
);

   mcr_pkg::queue_head_type queue_head;
   mcr_pkg::back_ctl_type   back_ctl;

   mcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .pop        (back_ctl.pop),
      .queue_head (queue_head)
   );

   mcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_head (queue_head),
      .back_ctl   (back_ctl),
      .rsp_chan   (rsp_chan)
   );

   // engine pops only a queued command
   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      back_ctl.pop |-> queue_head.valid)
      else $error("engine popped an empty command queue");

   // a start always begins pixel emission
   a_start_emits: assert property (@(posedge clock) disable iff (reset)
      back_ctl.pop && !queue_head.cmd.is_step |=> back_ctl.mode == mcr_pkg::MODE_EMIT)
      else $error("start command did not begin emission");

   // a done result carries no pixel and closes its item
   a_done_form: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> !rsp_chan.pixel_valid && rsp_chan.last)
      else $error("malformed done result");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule
